[rtl/core/tsda_pkg.sv]
// ----------------------------------------------------------------------------
// tsda_pkg
// Shared constants and lookup functions for the temperature display alarm:
// segment patterns, register indexes, pipeline widths.
// ----------------------------------------------------------------------------
package tsda_pkg;

  // Field widths
  localparam int RAW_W   = 16;
  localparam int LIMIT_W = 8;
  localparam int SEG_W   = 8;
  localparam int MAG_W   = 12;   // whole-degree magnitude, 0..2048
  localparam int QUO_W   = 5;    // magnitude / 100, 0..20
  localparam int REM_W   = 7;    // magnitude % 100, 0..99
  localparam int DIG_W   = 4;

  // Reciprocal constants: floor(m*655/2^16) is m/100 or one less for m <= 2048,
  // floor(r*205/2^11) is exactly r/10 for r < 100.
  localparam int DIV100_MUL   = 655;
  localparam int DIV100_SHIFT = 16;
  localparam int DIV10_MUL    = 205;
  localparam int DIV10_SHIFT  = 11;
  localparam int HUNDRED      = 100;
  localparam int TEN          = 10;

  // Configuration register indexes
  localparam logic REG_HIGH_LIMIT = 1'b0;
  localparam logic REG_LOW_LIMIT  = 1'b1;

  // Register reset values
  localparam logic signed [LIMIT_W-1:0] HIGH_LIMIT_RST = 8'sd125;
  localparam logic signed [LIMIT_W-1:0] LOW_LIMIT_RST  = -8'sd55;

  // Segment patterns (common cathode)
  localparam logic [SEG_W-1:0] SEG_C     = 8'h39;
  localparam logic [SEG_W-1:0] SEG_MINUS = 8'h40;
  localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;
  localparam logic [SEG_W-1:0] SEG_DOT   = 8'h80;

  // Decimal digit to segment pattern
  function automatic logic [SEG_W-1:0] digit_seg(input logic [DIG_W-1:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

  // Fraction nibble (1/16 steps) to tenths digit: floor(n*625/1000)
  function automatic logic [DIG_W-1:0] nibble_tenths(input logic [3:0] n);
    logic [DIG_W-1:0] t;
    case (n)
      4'd0, 4'd1:   t = 4'd0;
      4'd2, 4'd3:   t = 4'd1;
      4'd4:         t = 4'd2;
      4'd5, 4'd6:   t = 4'd3;
      4'd7:         t = 4'd4;
      4'd8, 4'd9:   t = 4'd5;
      4'd10, 4'd11: t = 4'd6;
      4'd12:        t = 4'd7;
      4'd13, 4'd14: t = 4'd8;
      default:      t = 4'd9;
    endcase
    return t;
  endfunction

  // Control carried along the pipeline
  typedef struct packed {
    logic            valid;
    logic            neg;
    logic [DIG_W-1:0] tenths;
  } stage_ctl_t;

endpackage

[rtl/core/temperature_segment_display_alarm.sv]
// ----------------------------------------------------------------------------
// temperature_segment_display_alarm
// Converts a 1/16-degree sensor word into four segment bytes, a two-digit
// signed whole-degree value and a limit alarm.
// ----------------------------------------------------------------------------
// Path: an accepted input beat passes the stage 1, 2 and 3 registers, then the output register.
// Throughput: one beat per cycle; the four stages advance together and hold
// as a whole only while a finished beat sits stalled in the output register.
// Reset: synchronous, clears all stage valid bits and loads the limits with
// high 125 and low -55.
module temperature_segment_display_alarm (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [tsda_pkg::RAW_W-1:0]   raw_reading,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tsda_pkg::SEG_W-1:0]          segment_first,
  output logic [tsda_pkg::SEG_W-1:0]          segment_second,
  output logic [tsda_pkg::SEG_W-1:0]          segment_third,
  output logic [tsda_pkg::SEG_W-1:0]          segment_fourth,
  output logic signed [tsda_pkg::LIMIT_W-1:0] whole_degrees,
  output logic                                alarm,
  input  logic                                cfg_write,
  input  logic                                cfg_index,
  input  logic [tsda_pkg::LIMIT_W-1:0]        cfg_data
);
  import tsda_pkg::*;

  logic                       advance;
  logic signed [LIMIT_W-1:0]  high_limit;
  logic signed [LIMIT_W-1:0]  low_limit;

  // stage registers
  stage_ctl_t                 ctl1, ctl2, ctl3;
  logic [MAG_W-1:0]           mag1, mag2;
  logic [QUO_W-1:0]           quo2;
  logic [REM_W-1:0]           rem3;

  // combinational helpers
  logic [RAW_W-1:0]           neg_raw;
  logic [MAG_W-1:0]           mag_in;
  logic [MAG_W+9:0]           quo_prod;
  logic [MAG_W-1:0]           hund;
  logic [MAG_W-1:0]           rem_raw;
  logic [REM_W-1:0]           rem_fix;
  logic [14:0]                ten_prod;
  logic [DIG_W-1:0]           tens;
  logic [DIG_W-1:0]           units;
  logic [REM_W-1:0]           ten_times;
  logic signed [LIMIT_W-1:0]  whole_next;

  // Move the whole pipe unless the output beat is held
  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  // Limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      high_limit <= HIGH_LIMIT_RST;
      low_limit  <= LOW_LIMIT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_HIGH_LIMIT: high_limit <= cfg_data;
        REG_LOW_LIMIT:  low_limit  <= cfg_data;
        default:        ;
      endcase
    end
  end

  // Stage 1: sign, whole-degree magnitude, tenths digit
  assign neg_raw = ~raw_reading + 16'd1;
  assign mag_in  = raw_reading[RAW_W-1] ? neg_raw[RAW_W-1:4] : {1'b0, raw_reading[RAW_W-2:4]};

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1.valid <= 1'b0;
    end else if (advance) begin
      ctl1.valid  <= in_valid;
      ctl1.neg    <= raw_reading[RAW_W-1];
      ctl1.tenths <= nibble_tenths(raw_reading[3:0]);
      mag1        <= mag_in;
    end
  end

  // Stage 2: estimate magnitude / 100 by reciprocal
  assign quo_prod = mag1 * 10'(DIV100_MUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl2.valid <= 1'b0;
    end else if (advance) begin
      ctl2.valid  <= ctl1.valid;
      ctl2.neg    <= ctl1.neg;
      ctl2.tenths <= ctl1.tenths;
      mag2        <= mag1;
      quo2        <= quo_prod[DIV100_SHIFT +: QUO_W];
    end
  end

  // Stage 3: remainder with one correction step
  assign hund    = MAG_W'(quo2) * MAG_W'(HUNDRED);
  assign rem_raw = mag2 - hund;
  assign rem_fix = (rem_raw >= MAG_W'(HUNDRED)) ? REM_W'(rem_raw - MAG_W'(HUNDRED))
                                                : rem_raw[REM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl3.valid <= 1'b0;
    end else if (advance) begin
      ctl3.valid  <= ctl2.valid;
      ctl3.neg    <= ctl2.neg;
      ctl3.tenths <= ctl2.tenths;
      rem3        <= rem_fix;
    end
  end

  // Stage 4: split into digits, build segments, compare against limits
  assign ten_prod   = rem3 * 8'(DIV10_MUL);
  assign tens       = ten_prod[DIV10_SHIFT +: DIG_W];
  assign ten_times  = REM_W'(tens) * REM_W'(TEN);
  assign units      = DIG_W'(rem3 - ten_times);
  assign whole_next = ctl3.neg ? -$signed({1'b0, rem3}) : $signed({1'b0, rem3});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= ctl3.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      segment_fourth <= SEG_C;
      whole_degrees  <= whole_next;
      alarm          <= (whole_next >= high_limit) || (whole_next <= low_limit);
      if (ctl3.neg) begin
        segment_third <= digit_seg(units);
        if (tens != 4'd0) begin
          segment_second <= digit_seg(tens);
          segment_first  <= SEG_MINUS;
        end else begin
          segment_second <= SEG_MINUS;
          segment_first  <= SEG_BLANK;
        end
      end else begin
        segment_third  <= digit_seg(ctl3.tenths);
        segment_second <= digit_seg(units) | SEG_DOT;
        segment_first  <= (tens != 4'd0) ? digit_seg(tens) : SEG_BLANK;
      end
    end
  end

  // Checks
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    ctl3.valid |-> (rem3 < REM_W'(HUNDRED)))
    else $error("remainder stage out of range");

  a_whole_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((whole_degrees <= 8'sd99) && (whole_degrees >= -8'sd99)))
    else $error("whole degrees beyond two digits");

  a_minus_sign: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (segment_first == SEG_MINUS)) |-> whole_degrees[LIMIT_W-1])
    else $error("leading minus on a non-negative value");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input held without a stalled output beat");

  a_hold_pipe: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(ctl3) && $stable(rem3)))
    else $error("pipeline moved while output beat held");

endmodule
